@@ hdl/aatrm_pkg.sv @@
// ----------------------------------------------------------------------------
// aatrm_pkg
// Shared widths, fixed-point constants, the CORDIC arctangent table and the
// side-band record that travels through the CORDIC stages.
// ----------------------------------------------------------------------------
package aatrm_pkg;

  // Field widths
  localparam int IN_W  = 16;   // axis Q2.14, angle Q3.13
  localparam int OUT_W = 17;   // matrix entries Q3.14

  // CORDIC datapath (Q30)
  localparam int Z_W  = 35;    // angle accumulator
  localparam int XY_W = 34;    // x / y accumulators
  localparam int CS_W = 18;    // cos / sin in Q14
  localparam int T_W  = 19;    // t = 1 - cos in Q14
  localparam int AB_W = 32;    // axis component products, Q28
  localparam int TAB_W = 51;   // t * a * b, Q42
  localparam int SP_W = 34;    // a * s, Q28
  localparam int SUM_W = 52;   // Q42 entry sums
  localparam int RND_SH = 28;  // Q42 -> Q14
  localparam int ANG_SH = 17;  // Q13 -> Q30

  localparam int ATAN_COUNT = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [Z_W-1:0]  Q30_PI      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [XY_W-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [XY_W-1:0] CS_RND      = 34'sd32768;
  localparam logic signed [T_W-1:0]  Q14_ONE     = 19'sd16384;
  localparam logic signed [SUM_W-1:0] SUM_RND    = 52'sd134217728;
  localparam logic signed [OUT_W-1:0] OUT_MAX    = 17'sd65535;
  localparam logic signed [OUT_W-1:0] OUT_MIN    = -17'sd65536;

  // atan(2^-i) in Q30, truncated
  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_COUNT] = '{
    35'sh3243F6A8, 35'sh1DAC6705, 35'sh0FADBAFC, 35'sh07F56EA6,
    35'sh03FEAB76, 35'sh01FFD55B, 35'sh00FFFAAA, 35'sh007FFF55,
    35'sh003FFFEA, 35'sh001FFFFD, 35'sh000FFFFF, 35'sh0007FFFF,
    35'sh0003FFFF, 35'sh0001FFFF, 35'sh0000FFFF, 35'sh00007FFF,
    35'sh00003FFF, 35'sh00001FFF, 35'sh00000FFF, 35'sh000007FF,
    35'sh000003FF, 35'sh000001FF, 35'sh000000FF, 35'sh0000007F
  };

  // Axis data carried alongside the CORDIC
  typedef struct packed {
    logic signed [AB_W-1:0] xx;
    logic signed [AB_W-1:0] xy;
    logic signed [AB_W-1:0] xz;
    logic signed [AB_W-1:0] yy;
    logic signed [AB_W-1:0] yz;
    logic signed [AB_W-1:0] zz;
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
  } side_t;

endpackage

@@ hdl/axis_angle_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Rodrigues rotation matrix from an (unnormalized) axis and an angle.
// R = c*I + t*a*a^T + s*[a]x, c/s from an unrolled, pipelined CORDIC.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  in_      | input     | in_valid/in_stall  | axis_x, axis_y, axis_z, angle
//  out_     | output    | out_valid/out_stall| r00 .. r22 (row-major)
//
//  One transaction enters per cycle unless the output stalls. From acceptance
//  to out_valid it passes the input stage, one stage per CORDIC iteration, a
//  cos/sin rounding stage, a multiply stage, a sum stage and the output
//  register. Throughput is set by the unrolled CORDIC: one item per cycle.
//  rst_n (synchronous) clears all valid bits; datapath registers are not reset.
//  A stall on the output freezes the whole pipeline together, so bubbles are
//  held, nothing is dropped or repeated; in_stall is raised only while a
//  finished result waits and out_stall is high.
//
module axis_angle_to_rotation_matrix #(
  parameter int CORDIC_STAGES = aatrm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [aatrm_pkg::IN_W-1:0]  in_axis_x,
  input  logic signed [aatrm_pkg::IN_W-1:0]  in_axis_y,
  input  logic signed [aatrm_pkg::IN_W-1:0]  in_axis_z,
  input  logic signed [aatrm_pkg::IN_W-1:0]  in_angle,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r00,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r01,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r02,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r10,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r11,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r12,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r20,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r21,
  output logic signed [aatrm_pkg::OUT_W-1:0] out_r22
);

  localparam int N      = CORDIC_STAGES;
  localparam int OUT_W  = aatrm_pkg::OUT_W;
  localparam int Z_W    = aatrm_pkg::Z_W;
  localparam int XY_W   = aatrm_pkg::XY_W;
  localparam int CS_W   = aatrm_pkg::CS_W;
  localparam int T_W    = aatrm_pkg::T_W;
  localparam int AB_W   = aatrm_pkg::AB_W;
  localparam int TAB_W  = aatrm_pkg::TAB_W;
  localparam int SP_W   = aatrm_pkg::SP_W;
  localparam int SUM_W  = aatrm_pkg::SUM_W;
  localparam int RND_SH = aatrm_pkg::RND_SH;
  localparam int V_W    = SUM_W - RND_SH;
  localparam int SP_SH  = 14;  // Q28 -> Q42
  localparam int NUM_R  = 9;

  // Entry order in the sum / output arrays (row-major)
  localparam int R00 = 0;
  localparam int R01 = 1;
  localparam int R02 = 2;
  localparam int R10 = 3;
  localparam int R11 = 4;
  localparam int R12 = 5;
  localparam int R20 = 6;
  localparam int R21 = 7;
  localparam int R22 = 8;

  // Whole pipeline advances together unless a result is held at the output.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Input stage: range reduction into +-pi/2, axis products
  // --------------------------------------------------------------------------
  logic signed [Z_W-1:0]  z_in;
  logic signed [Z_W-1:0]  z0_nxt;
  logic                   flip0_nxt;
  aatrm_pkg::side_t       side0_nxt;

  always_comb begin
    z_in = Z_W'(in_angle) <<< aatrm_pkg::ANG_SH;
    if (z_in > aatrm_pkg::Q30_HALF_PI) begin
      z0_nxt    = z_in - aatrm_pkg::Q30_PI;
      flip0_nxt = 1'b1;
    end else if (z_in < -aatrm_pkg::Q30_HALF_PI) begin
      z0_nxt    = z_in + aatrm_pkg::Q30_PI;
      flip0_nxt = 1'b1;
    end else begin
      z0_nxt    = z_in;
      flip0_nxt = 1'b0;
    end
    side0_nxt.xx = AB_W'(in_axis_x) * AB_W'(in_axis_x);
    side0_nxt.xy = AB_W'(in_axis_x) * AB_W'(in_axis_y);
    side0_nxt.xz = AB_W'(in_axis_x) * AB_W'(in_axis_z);
    side0_nxt.yy = AB_W'(in_axis_y) * AB_W'(in_axis_y);
    side0_nxt.yz = AB_W'(in_axis_y) * AB_W'(in_axis_z);
    side0_nxt.zz = AB_W'(in_axis_z) * AB_W'(in_axis_z);
    side0_nxt.ax = in_axis_x;
    side0_nxt.ay = in_axis_y;
    side0_nxt.az = in_axis_z;
  end

  // Stage k holds the state after k CORDIC iterations.
  logic signed [XY_W-1:0] cx_r   [0:N];
  logic signed [XY_W-1:0] cy_r   [0:N];
  logic signed [Z_W-1:0]  cz_r   [0:N];
  logic                   flip_r [0:N];
  logic                   cv_r   [0:N];
  aatrm_pkg::side_t       side_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= in_valid;
    end
    if (adv) begin
      cx_r[0]   <= aatrm_pkg::Q30_GAIN;
      cy_r[0]   <= '0;
      cz_r[0]   <= z0_nxt;
      flip_r[0] <= flip0_nxt;
      side_r[0] <= side0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC iterations, one register stage each
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] cx_nxt [0:N-1];
  logic signed [XY_W-1:0] cy_nxt [0:N-1];
  logic signed [Z_W-1:0]  cz_nxt [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_comb begin
      if (!cz_r[i][Z_W-1]) begin
        cx_nxt[i] = cx_r[i] - (cy_r[i] >>> i);
        cy_nxt[i] = cy_r[i] + (cx_r[i] >>> i);
        cz_nxt[i] = cz_r[i] - aatrm_pkg::ATAN_Q30[i];
      end else begin
        cx_nxt[i] = cx_r[i] + (cy_r[i] >>> i);
        cy_nxt[i] = cy_r[i] - (cx_r[i] >>> i);
        cz_nxt[i] = cz_r[i] + aatrm_pkg::ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (adv) begin
        cv_r[i+1] <= cv_r[i];
      end
      if (adv) begin
        cx_r[i+1]   <= cx_nxt[i];
        cy_r[i+1]   <= cy_nxt[i];
        cz_r[i+1]   <= cz_nxt[i];
        flip_r[i+1] <= flip_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // cos / sin: undo range reduction, round Q30 -> Q14 (half up)
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] xf, yf, xr, yr;
  logic signed [CS_W-1:0] c_nxt, s_nxt;
  logic signed [T_W-1:0]  t_nxt;

  always_comb begin
    xf    = flip_r[N] ? -cx_r[N] : cx_r[N];
    yf    = flip_r[N] ? -cy_r[N] : cy_r[N];
    xr    = xf + aatrm_pkg::CS_RND;
    yr    = yf + aatrm_pkg::CS_RND;
    c_nxt = xr[XY_W-1:XY_W-CS_W];
    s_nxt = yr[XY_W-1:XY_W-CS_W];
    t_nxt = aatrm_pkg::Q14_ONE - T_W'(c_nxt);
  end

  logic signed [CS_W-1:0] c_r, s_r;
  logic signed [T_W-1:0]  t_r;
  logic                   csv_r;
  aatrm_pkg::side_t       cs_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csv_r <= 1'b0;
    end else if (adv) begin
      csv_r <= cv_r[N];
    end
    if (adv) begin
      c_r       <= c_nxt;
      s_r       <= s_nxt;
      t_r       <= t_nxt;
      cs_side_r <= side_r[N];
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: t*ab (Q42) and a*s (Q28)
  // --------------------------------------------------------------------------
  logic signed [TAB_W-1:0] txx_r, txy_r, txz_r, tyy_r, tyz_r, tzz_r;
  logic signed [SP_W-1:0]  xs_r, ys_r, zs_r;
  logic signed [CS_W-1:0]  cm_r;
  logic                    mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= csv_r;
    end
    if (adv) begin
      txx_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.xx);
      txy_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.xy);
      txz_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.xz);
      tyy_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.yy);
      tyz_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.yz);
      tzz_r <= TAB_W'(t_r) * TAB_W'(cs_side_r.zz);
      xs_r  <= SP_W'(cs_side_r.ax) * SP_W'(s_r);
      ys_r  <= SP_W'(cs_side_r.ay) * SP_W'(s_r);
      zs_r  <= SP_W'(cs_side_r.az) * SP_W'(s_r);
      cm_r  <= c_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sum stage: Q42 sums with the rounding constant folded in
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] cq, xq, yq, zq;
  logic signed [SUM_W-1:0] sum_nxt [NUM_R];
  logic signed [SUM_W-1:0] sum_r   [NUM_R];
  logic                    sv_r;

  always_comb begin
    cq = SUM_W'(cm_r) <<< RND_SH;
    xq = SUM_W'(xs_r) <<< SP_SH;
    yq = SUM_W'(ys_r) <<< SP_SH;
    zq = SUM_W'(zs_r) <<< SP_SH;
    sum_nxt[R00] = SUM_W'(txx_r) + cq + aatrm_pkg::SUM_RND;
    sum_nxt[R01] = SUM_W'(txy_r) - zq + aatrm_pkg::SUM_RND;
    sum_nxt[R02] = SUM_W'(txz_r) + yq + aatrm_pkg::SUM_RND;
    sum_nxt[R10] = SUM_W'(txy_r) + zq + aatrm_pkg::SUM_RND;
    sum_nxt[R11] = SUM_W'(tyy_r) + cq + aatrm_pkg::SUM_RND;
    sum_nxt[R12] = SUM_W'(tyz_r) - xq + aatrm_pkg::SUM_RND;
    sum_nxt[R20] = SUM_W'(txz_r) - yq + aatrm_pkg::SUM_RND;
    sum_nxt[R21] = SUM_W'(tyz_r) + xq + aatrm_pkg::SUM_RND;
    sum_nxt[R22] = SUM_W'(tzz_r) + cq + aatrm_pkg::SUM_RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (adv) begin
      sv_r <= mv_r;
    end
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: shift to Q14 and clamp to 17 bits
  // --------------------------------------------------------------------------
  logic signed [V_W-1:0]   v      [NUM_R];
  logic signed [OUT_W-1:0] r_nxt  [NUM_R];
  logic signed [OUT_W-1:0] r_r    [NUM_R];
  logic                    out_valid_r;

  always_comb begin
    for (int k = 0; k < NUM_R; k++) begin
      v[k] = sum_r[k][SUM_W-1:RND_SH];
      if (v[k] > V_W'(aatrm_pkg::OUT_MAX)) begin
        r_nxt[k] = aatrm_pkg::OUT_MAX;
      end else if (v[k] < V_W'(aatrm_pkg::OUT_MIN)) begin
        r_nxt[k] = aatrm_pkg::OUT_MIN;
      end else begin
        r_nxt[k] = v[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r;
    end
    if (adv) begin
      r_r <= r_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_r00   = r_r[R00];
  assign out_r01   = r_r[R01];
  assign out_r02   = r_r[R02];
  assign out_r10   = r_r[R10];
  assign out_r11   = r_r[R11];
  assign out_r12   = r_r[R12];
  assign out_r20   = r_r[R20];
  assign out_r21   = r_r[R21];
  assign out_r22   = r_r[R22];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input back-pressure only comes from a held result.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // CORDIC output stays near unit magnitude.
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    csv_r |-> (c_r <= 18'sd16400 && c_r >= -18'sd16400))
    else $error("cosine out of range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    csv_r |-> (s_r <= 18'sd16400 && s_r >= -18'sd16400))
    else $error("sine out of range");

  // A frozen pipeline keeps the held result unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(r_r[R00]) && $stable(r_r[R22]) && out_valid))
    else $error("held result changed");

endmodule
